>>> rtl/core/key_scan_to_midi_encoder_unit_assert.svh
// Assertion macros for the key scan to MIDI encoder checker.
// Depends on signals named clk and rst_n in the scope of each use.
`ifndef KEY_SCAN_TO_MIDI_ENCODER_UNIT_ASSERT_SVH
`define KEY_SCAN_TO_MIDI_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication, off while in reset
`define KSTM_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kstm check failed");

// Next-cycle implication, off while in reset
`define KSTM_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kstm check failed");

`endif

>>> rtl/core/kstm_pkg.sv
// Package for the key scan to MIDI encoder: sizes, MIDI codes, register map,
// and the command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kstm_pkg;

  // Key matrix size
  localparam int NUM_KEYS   = 20;
  localparam int KEY_W      = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int STEP_W     = KEY_W + 1;
  localparam int MASK_W     = 32;
  localparam int MASK_IDX_W = 5;

  // Field widths
  localparam int TURN_W  = 4;
  localparam int PEND_W  = 8;
  localparam int VAL_W   = 7;
  localparam int ST_W    = 8;

  // Per-scan message limit
  localparam int MAX_MSGS = 40;
  localparam int CNT_W    = $clog2(MAX_MSGS + 1);

  // MIDI codes and limits
  localparam logic [ST_W-1:0]  ST_NOTE_ON  = 8'h90;
  localparam logic [ST_W-1:0]  ST_NOTE_OFF = 8'h80;
  localparam logic [ST_W-1:0]  ST_CC       = 8'hB0;
  localparam logic [VAL_W-1:0] VAL_MAX     = 7'd127;
  localparam logic [VAL_W-1:0] VAL_ZERO    = 7'd0;
  localparam logic [PEND_W-1:0] PEND_MAX   = 8'd255;
  localparam logic [VAL_W-1:0] BASE_RESET  = 7'd36;
  localparam logic [VAL_W-1:0] CC_LSB_OFS  = 7'd16;
  localparam logic [VAL_W-1:0] CC_MSB_OFS  = 7'd48;

  // Route codes on the output
  localparam logic ROUTE_SERIAL = 1'b0;
  localparam logic ROUTE_USB    = 1'b1;

  // Configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_BASE_DOWN = 2'd0;
  localparam logic [1:0] REG_BASE_UP   = 2'd1;
  localparam logic [1:0] REG_MODE      = 2'd2;
  localparam logic [1:0] REG_ROUTE     = 2'd3;
  localparam logic [MASK_IDX_W-1:0] BASE_DOWN_RESET = 5'd20;
  localparam logic [MASK_IDX_W-1:0] BASE_UP_RESET   = 5'd21;
  localparam logic [MASK_IDX_W-1:0] MODE_RESET      = 5'd22;
  localparam logic [MASK_IDX_W-1:0] ROUTE_RESET     = 5'd23;

  // Function key positions
  typedef struct packed {
    logic [MASK_IDX_W-1:0] base_down_key;
    logic [MASK_IDX_W-1:0] base_up_key;
    logic [MASK_IDX_W-1:0] mode_key;
    logic [MASK_IDX_W-1:0] route_key;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic             load;
    logic             func;
    logic             scan;
    logic [KEY_W-1:0] key;
    logic             phase;
    logic             cc_first;
    logic             cc_second;
    logic             flush;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic stall;
    logic func_hit;
    logic turn_go;
    logic serial;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/core/kstm_channels.sv
// Valid/ready channel interfaces for key scan items and MIDI message items.
// Depends on kstm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface kstm_in_if;
  logic                             valid;
  logic                             ready;
  logic [kstm_pkg::MASK_W-1:0]      press_mask;
  logic [kstm_pkg::MASK_W-1:0]      release_mask;
  logic [kstm_pkg::TURN_W-1:0]      turns_left;
  logic [kstm_pkg::TURN_W-1:0]      turns_right;
  logic                             usb_ready;

  modport source (output valid, press_mask, release_mask, turns_left, turns_right,
                  usb_ready, input ready);
  modport sink   (input valid, press_mask, release_mask, turns_left, turns_right,
                  usb_ready, output ready);
endinterface

interface kstm_out_if;
  logic                        valid;
  logic                        ready;
  logic                        route;
  logic [kstm_pkg::ST_W-1:0]   status_byte;
  logic [kstm_pkg::VAL_W-1:0]  data_one;
  logic [kstm_pkg::VAL_W-1:0]  data_two;
  logic                        last;

  modport source (output valid, route, status_byte, data_one, data_two, last,
                  input ready);
  modport sink   (input valid, route, status_byte, data_one, data_two, last,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/kstm_cfg.sv
// APB-style register file holding the four function key positions.
// Depends on kstm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kstm_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [kstm_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [kstm_pkg::DATA_W-1:0]   pwdata,
  output logic      [kstm_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output kstm_pkg::cfg_t                     cfg
);

  kstm_pkg::cfg_t cfg_r, cfg_nxt;
  logic           wr_en;
  logic [1:0]     idx;
  logic [kstm_pkg::MASK_IDX_W-1:0] wval;
  logic [kstm_pkg::MASK_IDX_W-1:0] rval;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[3:2];
  assign wval   = pwdata[kstm_pkg::MASK_IDX_W-1:0];

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        kstm_pkg::REG_BASE_DOWN: cfg_nxt.base_down_key = wval;
        kstm_pkg::REG_BASE_UP:   cfg_nxt.base_up_key   = wval;
        kstm_pkg::REG_MODE:      cfg_nxt.mode_key      = wval;
        kstm_pkg::REG_ROUTE:     cfg_nxt.route_key     = wval;
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_down_key <= kstm_pkg::BASE_DOWN_RESET;
      cfg_r.base_up_key   <= kstm_pkg::BASE_UP_RESET;
      cfg_r.mode_key      <= kstm_pkg::MODE_RESET;
      cfg_r.route_key     <= kstm_pkg::ROUTE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      kstm_pkg::REG_BASE_DOWN: rval = cfg_r.base_down_key;
      kstm_pkg::REG_BASE_UP:   rval = cfg_r.base_up_key;
      kstm_pkg::REG_MODE:      rval = cfg_r.mode_key;
      kstm_pkg::REG_ROUTE:     rval = cfg_r.route_key;
      default:                 rval = '0;
    endcase
  end

  assign prdata = kstm_pkg::DATA_W'(rval);
  assign cfg    = cfg_r;

endmodule

`default_nettype wire

>>> rtl/core/kstm_ctrl.sv
// Sequencer for one key scan: load, function keys, key walk, CC turn, flush.
// Depends on kstm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kstm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  kstm_pkg::sts_t      sts,
  output kstm_pkg::cmd_t      cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_FUNC  = 6'b000010,
    ST_SCAN  = 6'b000100,
    ST_TURN  = 6'b001000,
    ST_TURN2 = 6'b010000,
    ST_FLUSH = 6'b100000
  } state_t;

  localparam logic [kstm_pkg::STEP_W-1:0] STEP_LAST =
    kstm_pkg::STEP_W'(2 * kstm_pkg::NUM_KEYS - 1);

  state_t                        state_r, state_nxt;
  logic [kstm_pkg::STEP_W-1:0]   step_r, step_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.key   = step_r[kstm_pkg::STEP_W-1:1];
    cmd.phase = step_r[0];
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_FUNC;
        end
      end
      ST_FUNC: begin
        cmd.func  = 1'b1;
        step_nxt  = '0;
        state_nxt = sts.func_hit ? ST_TURN : ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (!sts.stall) begin
          if (step_r == STEP_LAST) begin
            state_nxt = ST_TURN;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
      end
      ST_TURN: begin
        cmd.cc_first = 1'b1;
        if (!sts.stall) begin
          state_nxt = (sts.turn_go && sts.serial) ? ST_TURN2 : ST_FLUSH;
        end
      end
      ST_TURN2: begin
        cmd.cc_second = 1'b1;
        if (!sts.stall) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        if (!sts.stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/kstm_dp.sv
// Datapath: scan latch, note/CC state, CC value store, message hold stage and
// output register. Depends on kstm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kstm_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  kstm_pkg::cfg_t                     cfg,
  input  kstm_pkg::cmd_t                     cmd,
  output kstm_pkg::sts_t                     sts,
  input  wire logic [kstm_pkg::MASK_W-1:0]   press_mask,
  input  wire logic [kstm_pkg::MASK_W-1:0]   release_mask,
  input  wire logic [kstm_pkg::TURN_W-1:0]   turns_left,
  input  wire logic [kstm_pkg::TURN_W-1:0]   turns_right,
  input  wire logic                          usb_ready,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               route,
  output logic      [kstm_pkg::ST_W-1:0]     status_byte,
  output logic      [kstm_pkg::VAL_W-1:0]    data_one,
  output logic      [kstm_pkg::VAL_W-1:0]    data_two,
  output logic                               last
);

  localparam int VAL_W  = kstm_pkg::VAL_W;
  localparam int PEND_W = kstm_pkg::PEND_W;
  localparam int KEY_W  = kstm_pkg::KEY_W;

  typedef struct packed {
    logic                   route;
    logic [kstm_pkg::ST_W-1:0] status_byte;
    logic [VAL_W-1:0]       data_one;
    logic [VAL_W-1:0]       data_two;
  } msg_t;

  // Latched scan
  logic [kstm_pkg::MASK_W-1:0] press_r, release_r;
  logic                        usb_r;

  // Encoder state
  logic [VAL_W-1:0]            base_r, base_nxt;
  logic                        cc_mode_r, cc_mode_nxt;
  logic [KEY_W-1:0]            slot_r, slot_nxt;
  logic                        serial_r, serial_nxt;
  logic [PEND_W-1:0]           pl_r, pl_nxt, pr_r, pr_nxt;
  logic [VAL_W-1:0]            cc_values_r [kstm_pkg::NUM_KEYS];
  logic                        cc_wr;

  // Message path
  msg_t                        held_r, held_nxt, out_r, out_nxt;
  logic                        held_v_r, held_v_nxt, out_v_r, out_v_nxt;
  logic                        last_r, last_nxt;
  logic [kstm_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;

  logic                        hit_down, hit_up, hit_mode, hit_route;
  logic [kstm_pkg::MASK_IDX_W-1:0] key_idx;
  logic [VAL_W:0]              note_sum;
  logic [VAL_W-1:0]            note;
  logic [KEY_W-1:0]            slot_eff;
  logic [VAL_W-1:0]            slot_val;
  logic [VAL_W-1:0]            slot_ext;
  logic signed [VAL_W+2:0]     turn_sum;
  logic [VAL_W-1:0]            turn_val;
  logic [PEND_W:0]             pl_sum, pr_sum;
  logic                        turn_go;
  logic                        req, allow, busy, stall, push;
  msg_t                        req_msg;

  // Function key decode on the latched scan
  assign hit_down  = press_r[cfg.base_down_key];
  assign hit_up    = press_r[cfg.base_up_key];
  assign hit_mode  = press_r[cfg.mode_key];
  assign hit_route = press_r[cfg.route_key];

  // Note number, clamped
  assign key_idx  = kstm_pkg::MASK_IDX_W'(cmd.key);
  assign note_sum = {1'b0, base_r} + (VAL_W + 1)'(cmd.key);
  assign note     = note_sum[VAL_W] ? kstm_pkg::VAL_MAX : note_sum[VAL_W-1:0];

  // Selected CC entry and turn result
  assign slot_eff = (32'(slot_r) < kstm_pkg::NUM_KEYS) ? slot_r : '0;
  assign slot_val = cc_values_r[slot_eff];
  assign slot_ext = VAL_W'(slot_eff);
  assign turn_go  = cc_mode_r && ((pl_r != '0) || (pr_r != '0));
  assign turn_sum = $signed({3'b000, slot_val}) + $signed({2'b00, pr_r})
                  - $signed({2'b00, pl_r});
  always_comb begin
    if (turn_sum < 0) begin
      turn_val = kstm_pkg::VAL_ZERO;
    end else if (turn_sum > $signed({3'b000, kstm_pkg::VAL_MAX})) begin
      turn_val = kstm_pkg::VAL_MAX;
    end else begin
      turn_val = turn_sum[VAL_W-1:0];
    end
  end

  // Message request for this step
  always_comb begin
    req             = 1'b0;
    req_msg.route   = serial_r ? kstm_pkg::ROUTE_SERIAL : kstm_pkg::ROUTE_USB;
    req_msg.status_byte = kstm_pkg::ST_CC;
    req_msg.data_one    = slot_ext;
    req_msg.data_two    = kstm_pkg::VAL_ZERO;
    if (cmd.scan && !cc_mode_r) begin
      req_msg.data_one = note;
      if (!cmd.phase) begin
        req                 = press_r[key_idx];
        req_msg.status_byte = kstm_pkg::ST_NOTE_ON;
        req_msg.data_two    = kstm_pkg::VAL_MAX;
      end else begin
        req                 = release_r[key_idx];
        req_msg.status_byte = kstm_pkg::ST_NOTE_OFF;
        req_msg.data_two    = kstm_pkg::VAL_ZERO;
      end
    end else if (cmd.cc_first && turn_go) begin
      req = 1'b1;
      if (serial_r) begin
        req_msg.data_one = slot_ext + kstm_pkg::CC_LSB_OFS;
        req_msg.data_two = kstm_pkg::VAL_ZERO;
      end else begin
        req_msg.data_two = turn_val;
      end
    end else if (cmd.cc_second) begin
      req              = 1'b1;
      req_msg.data_one = slot_ext + kstm_pkg::CC_MSB_OFS;
      req_msg.data_two = slot_val;
    end
  end

  // Hold stage: a message waits here until the next one shows it was not last
  assign allow = req && (serial_r || usb_r) && (32'(cnt_r) < kstm_pkg::MAX_MSGS);
  assign busy  = out_v_r && !out_ready;
  assign stall = held_v_r && busy && (allow || cmd.flush);
  assign push  = held_v_r && !busy && (allow || cmd.flush);

  always_comb begin
    held_nxt   = held_r;
    held_v_nxt = held_v_r;
    cnt_nxt    = cnt_r;
    out_nxt    = out_r;
    last_nxt   = last_r;
    out_v_nxt  = out_ready ? 1'b0 : out_v_r;
    if (cmd.load) begin
      cnt_nxt = '0;
    end
    if (push) begin
      out_nxt   = held_r;
      last_nxt  = cmd.flush;
      out_v_nxt = 1'b1;
    end
    if (!stall) begin
      if (allow) begin
        held_nxt   = req_msg;
        held_v_nxt = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
      end else if (cmd.flush) begin
        held_v_nxt = 1'b0;
      end
    end
  end

  // Encoder state updates
  assign pl_sum = {1'b0, pl_r} + (PEND_W + 1)'(turns_left);
  assign pr_sum = {1'b0, pr_r} + (PEND_W + 1)'(turns_right);
  assign cc_wr  = cmd.cc_first && turn_go && !stall;

  always_comb begin
    base_nxt    = base_r;
    cc_mode_nxt = cc_mode_r;
    slot_nxt    = slot_r;
    serial_nxt  = serial_r;
    pl_nxt      = pl_r;
    pr_nxt      = pr_r;
    if (cmd.load) begin
      pl_nxt = pl_sum[PEND_W] ? kstm_pkg::PEND_MAX : pl_sum[PEND_W-1:0];
      pr_nxt = pr_sum[PEND_W] ? kstm_pkg::PEND_MAX : pr_sum[PEND_W-1:0];
    end
    if (cmd.func) begin
      if (hit_down) begin
        if (base_r != kstm_pkg::VAL_ZERO) base_nxt = base_r - 1'b1;
      end else if (hit_up) begin
        if (base_r != kstm_pkg::VAL_MAX) base_nxt = base_r + 1'b1;
      end else if (hit_mode) begin
        cc_mode_nxt = !cc_mode_r;
        slot_nxt    = '0;
      end else if (hit_route) begin
        serial_nxt = !serial_r;
      end
    end
    // CC mode: the highest pressed key wins, as the walk is ascending
    if (cmd.scan && cc_mode_r && !cmd.phase && press_r[key_idx]) begin
      slot_nxt = cmd.key;
    end
    if (cc_wr) begin
      pl_nxt = '0;
      pr_nxt = '0;
    end
  end

  // Scan latch and message payload (no reset needed)
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      press_r   <= press_mask;
      release_r <= release_mask;
      usb_r     <= usb_ready;
    end
    held_r <= held_nxt;
    out_r  <= out_nxt;
    last_r <= last_nxt;
  end

  // Control and encoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= kstm_pkg::BASE_RESET;
      cc_mode_r <= 1'b0;
      slot_r    <= '0;
      serial_r  <= 1'b1;
      pl_r      <= '0;
      pr_r      <= '0;
      held_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
      cnt_r     <= '0;
    end else begin
      base_r    <= base_nxt;
      cc_mode_r <= cc_mode_nxt;
      slot_r    <= slot_nxt;
      serial_r  <= serial_nxt;
      pl_r      <= pl_nxt;
      pr_r      <= pr_nxt;
      held_v_r  <= held_v_nxt;
      out_v_r   <= out_v_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  // CC value store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < kstm_pkg::NUM_KEYS; i++) begin
        cc_values_r[i] <= '0;
      end
    end else if (cc_wr) begin
      cc_values_r[slot_eff] <= turn_val;
    end
  end

  assign sts.stall    = stall;
  assign sts.func_hit = hit_down || hit_up || hit_mode || hit_route;
  assign sts.turn_go  = turn_go;
  assign sts.serial   = serial_r;

  assign out_valid   = out_v_r;
  assign route       = out_r.route;
  assign status_byte = out_r.status_byte;
  assign data_one    = out_r.data_one;
  assign data_two    = out_r.data_two;
  assign last        = last_r;

endmodule

`default_nettype wire

>>> rtl/core/key_scan_to_midi_encoder_unit.sv
// Key scan to MIDI encoder. One key scan item is taken at a time and turned
// into up to 40 MIDI message items, the final one flagged by last. A scan
// passes an accept step, a function key step, a key walk with one step for
// each press and release slot, then the CC turn, a second CC turn step when a
// turn is due on the serial route, and a flush step. The key walk is skipped
// when a function key is pressed, and the output side can stall the walk, the
// turn and the flush. The next scan can be taken while the final message
// still sits in the output register. Function key positions sit in four APB
// registers at byte addresses 0, 4, 8 and 12.
// Depends on kstm_pkg, kstm_channels, kstm_cfg, kstm_ctrl and kstm_dp.
`timescale 1ns / 1ps
`default_nettype none

module key_scan_to_midi_encoder_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  kstm_in_if.sink                            in_ch,
  kstm_out_if.source                         out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [kstm_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [kstm_pkg::DATA_W-1:0]   pwdata,
  output logic      [kstm_pkg::DATA_W-1:0]   prdata,
  output logic                               pready
);

  kstm_pkg::cfg_t cfg;
  kstm_pkg::cmd_t cmd;
  kstm_pkg::sts_t sts;

  // Configuration registers
  kstm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer
  kstm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath
  kstm_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .cmd          (cmd),
    .sts          (sts),
    .press_mask   (in_ch.press_mask),
    .release_mask (in_ch.release_mask),
    .turns_left   (in_ch.turns_left),
    .turns_right  (in_ch.turns_right),
    .usb_ready    (in_ch.usb_ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .route        (out_ch.route),
    .status_byte  (out_ch.status_byte),
    .data_one     (out_ch.data_one),
    .data_two     (out_ch.data_two),
    .last         (out_ch.last)
  );

endmodule

`default_nettype wire

>>> rtl/core/kstm_chk.sv
// Port-level checker for the key scan to MIDI encoder, bound to the top level.
// Depends on kstm_pkg and key_scan_to_midi_encoder_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "key_scan_to_midi_encoder_unit_assert.svh"

module kstm_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [kstm_pkg::ST_W-1:0]   status_byte,
  input wire logic [kstm_pkg::VAL_W-1:0]  data_two
);

  // A waiting item stays offered
  `KSTM_AST_NXT(a_out_hold, out_valid && !out_ready, out_valid)

  // One scan at a time: no item taken right after another
  `KSTM_AST_NXT(a_one_scan, in_valid && in_ready, !in_ready)

  // Only note on, note off and control change are produced
  `KSTM_AST_IMP(a_status, out_valid, status_byte == kstm_pkg::ST_NOTE_ON || status_byte == kstm_pkg::ST_NOTE_OFF || status_byte == kstm_pkg::ST_CC)

  // Note on carries full velocity, note off zero
  `KSTM_AST_IMP(a_velocity, out_valid && status_byte != kstm_pkg::ST_CC, (status_byte == kstm_pkg::ST_NOTE_ON && data_two == kstm_pkg::VAL_MAX) || (status_byte == kstm_pkg::ST_NOTE_OFF && data_two == kstm_pkg::VAL_ZERO))

endmodule

bind key_scan_to_midi_encoder_unit kstm_chk u_kstm_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .status_byte (out_ch.status_byte),
  .data_two    (out_ch.data_two)
);

`default_nettype wire
